FILE: sv/spectral_flux_onset_detector_unit_defines.svh
// ---------------------------------------------------------------------------
// Spectral flux onset detector: assertion macros
// Shared property forms, clocked on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef SPECTRAL_FLUX_ONSET_DETECTOR_UNIT_DEFINES_SVH
`define SPECTRAL_FLUX_ONSET_DETECTOR_UNIT_DEFINES_SVH

// expression must never hold
`define SFOD_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

// same-cycle implication
`define SFOD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SFOD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/sfod_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfod_pkg
// Shared constants, register codes and types of the onset detector.
// ---------------------------------------------------------------------------
package sfod_pkg;

	localparam int DEF_MAX_BINS   = 512;
	localparam int DEF_MAX_WINDOW = 64;
	localparam int DEF_MAG_BITS   = 16;

	localparam int FRAME_BINS_W = 10;
	localparam int WINDOW_W     = 7;
	localparam int GAIN_W       = 16;
	localparam int GAIN_FRAC    = 12;
	localparam int CFG_ADDR_W   = 2;
	localparam int CFG_DATA_W   = 16;
	localparam int STATE_W      = 2;

	localparam logic [FRAME_BINS_W-1:0] RST_FRAME_BINS = FRAME_BINS_W'(512);
	localparam logic [WINDOW_W-1:0]     RST_WINDOW     = WINDOW_W'(8);
	localparam logic [GAIN_W-1:0]       RST_GAIN       = GAIN_W'(4096);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_FRAME_BINS    = 2'd0,
		CFG_WINDOW_LENGTH = 2'd1,
		CFG_GAIN          = 2'd2
	} cfg_index_t;

	typedef enum logic [STATE_W-1:0] {
		ST_NONE     = 2'd0,
		ST_BEGIN    = 2'd1,
		ST_DURATION = 2'd2,
		ST_ENDED    = 2'd3
	} onset_t;

	typedef struct packed {
		logic [FRAME_BINS_W-1:0] frame_bins;
		logic [WINDOW_W-1:0]     window_length;
		logic [GAIN_W-1:0]       gain;
	} cfg_regs_t;

	typedef struct packed {
		logic [FIFO_CNT_W-1:0] count;
		logic                  empty;
	} fifo_status_t;

endpackage

FILE: sv/sfod_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfod_front
// Bin intake: previous-frame store, absolute difference and flux sum.
// ---------------------------------------------------------------------------
module sfod_front #(
	parameter int MAX_BINS = sfod_pkg::DEF_MAX_BINS,
	parameter int MAG_BITS = sfod_pkg::DEF_MAG_BITS,
	parameter int FLUX_W   = sfod_pkg::DEF_MAG_BITS + $clog2(sfod_pkg::DEF_MAX_BINS)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   clear,
	input  sfod_pkg::cfg_regs_t    cfg,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [MAG_BITS-1:0]    mag,
	input  sfod_pkg::fifo_status_t fifo_stat,
	output logic                   push,
	output logic [FLUX_W-1:0]      push_data
);

	localparam int ADDR_W = $clog2(MAX_BINS);
	localparam int NB_W   = $clog2(MAX_BINS + 1);

	logic [MAG_BITS-1:0] prev_mem [MAX_BINS];

	logic [NB_W-1:0]     nb_eff;
	logic                last_bin;
	logic                accept;
	logic                fwd_now;
	logic [ADDR_W-1:0]   bin_cnt_q;
	logic                first_q;
	logic [FLUX_W-1:0]   acc_q;

	logic                vld_s1;
	logic [MAG_BITS-1:0] mag_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic                last_s1;
	logic                fwd_s1;
	logic                old_ok_s1;
	logic [MAG_BITS-1:0] fwd_val_s1;
	logic [MAG_BITS-1:0] rd_s1;

	logic [MAG_BITS-1:0] old_mag;
	logic [MAG_BITS-1:0] diff;
	logic [FLUX_W-1:0]   acc_sum;

	always_comb begin
		if (cfg.frame_bins == '0) begin
			nb_eff = NB_W'(1);
		end else if (32'(cfg.frame_bins) > 32'(MAX_BINS)) begin
			nb_eff = NB_W'(MAX_BINS);
		end else begin
			nb_eff = NB_W'(cfg.frame_bins);
		end
	end

	assign last_bin = (bin_cnt_q == ADDR_W'(nb_eff - NB_W'(1)));
	// room for the frame end already in flight
	assign s_tready = (32'(fifo_stat.count) + 32'(vld_s1 && last_s1)) < sfod_pkg::FIFO_DEPTH;
	assign accept   = s_tvalid && s_tready;
	assign fwd_now  = vld_s1 && (addr_s1 == bin_cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			bin_cnt_q <= '0;
			first_q   <= 1'b1;
			acc_q     <= '0;
		end else if (clear) begin
			vld_s1    <= 1'b0;
			bin_cnt_q <= '0;
			first_q   <= 1'b1;
			acc_q     <= '0;
		end else begin
			vld_s1 <= accept;
			if (accept) begin
				bin_cnt_q <= last_bin ? '0 : bin_cnt_q + ADDR_W'(1);
				if (last_bin) begin
					first_q <= 1'b0;
				end
			end
			if (vld_s1) begin
				acc_q <= last_s1 ? '0 : acc_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_s1     <= mag;
			addr_s1    <= bin_cnt_q;
			last_s1    <= last_bin;
			fwd_s1     <= fwd_now;
			old_ok_s1  <= !first_q || fwd_now;
			fwd_val_s1 <= mag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			prev_mem[addr_s1] <= mag_s1;
		end
		if (accept) begin
			rd_s1 <= prev_mem[bin_cnt_q];
		end
	end

	always_comb begin
		if (!old_ok_s1) begin
			old_mag = '0;
		end else if (fwd_s1) begin
			old_mag = fwd_val_s1;
		end else begin
			old_mag = rd_s1;
		end
		diff    = (mag_s1 >= old_mag) ? (mag_s1 - old_mag) : (old_mag - mag_s1);
		acc_sum = acc_q + FLUX_W'(diff);
	end

	assign push      = vld_s1 && last_s1;
	assign push_data = acc_sum;

endmodule

FILE: sv/sfod_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfod_fifo
// Short first-word-fall-through queue of finished frame flux values.
// ---------------------------------------------------------------------------
module sfod_fifo #(
	parameter int WIDTH = sfod_pkg::DEF_MAG_BITS + $clog2(sfod_pkg::DEF_MAX_BINS)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   clear,
	input  logic                   push,
	input  logic [WIDTH-1:0]       push_data,
	input  logic                   pop,
	output logic [WIDTH-1:0]       pop_data,
	output sfod_pkg::fifo_status_t stat
);

	localparam int PW = sfod_pkg::FIFO_PTR_W;
	localparam int CW = sfod_pkg::FIFO_CNT_W;

	logic [WIDTH-1:0] slot_q [sfod_pkg::FIFO_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_pop;

	assign do_pop = pop && (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else if (clear) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(sfod_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(sfod_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data   = slot_q[rd_ptr_q];
	assign stat.count = cnt_q;
	assign stat.empty = (cnt_q == '0);

endmodule

FILE: sv/sfod_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfod_back
// Flux ring, running sum, threshold compare, onset state and result register.
// ---------------------------------------------------------------------------
module sfod_back #(
	parameter int MAX_WINDOW = sfod_pkg::DEF_MAX_WINDOW,
	parameter int FLUX_W     = sfod_pkg::DEF_MAG_BITS + $clog2(sfod_pkg::DEF_MAX_BINS)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  sfod_pkg::cfg_regs_t           cfg,
	input  sfod_pkg::fifo_status_t        fifo_stat,
	input  logic [FLUX_W-1:0]             fifo_data,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [sfod_pkg::STATE_W-1:0]  res_state,
	output logic [FLUX_W-1:0]             res_flux
);

	localparam int POS_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int NW_W  = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W = FLUX_W + $clog2(MAX_WINDOW);
	localparam int LHS_W = FLUX_W + NW_W;
	localparam int RHS_W = SUM_W + sfod_pkg::GAIN_W;
	localparam int CMP_W = (LHS_W + sfod_pkg::GAIN_FRAC > RHS_W) ?
		LHS_W + sfod_pkg::GAIN_FRAC : RHS_W;

	logic [FLUX_W-1:0] ring_mem [MAX_WINDOW];

	logic [NW_W-1:0]   nw_eff;
	logic              adv;
	logic              last_pos;
	logic              fwd_now;
	logic [POS_W-1:0]  pos_q;
	logic              wrapped_q;
	logic [SUM_W-1:0]  sum_q;
	logic              out_vld_q;
	logic [FLUX_W-1:0] out_flux_q;
	sfod_pkg::onset_t  state_q;
	sfod_pkg::onset_t  state_next;

	logic              vld_s1;
	logic [FLUX_W-1:0] flux_s1;
	logic [POS_W-1:0]  pos_s1;
	logic              fwd_s1;
	logic              old_ok_s1;
	logic [FLUX_W-1:0] fwd_val_s1;
	logic [FLUX_W-1:0] rd_s1;

	logic              vld_s2;
	logic [FLUX_W-1:0] flux_s2;
	logic [SUM_W-1:0]  sum_s2;
	logic [LHS_W-1:0]  lhs_s2;

	logic              vld_s3;
	logic [FLUX_W-1:0] flux_s3;
	logic [LHS_W-1:0]  lhs_s3;
	logic [RHS_W-1:0]  rhs_s3;

	logic [FLUX_W-1:0] old_flux;
	logic [SUM_W-1:0]  sum_new;
	logic [CMP_W-1:0]  lhs_cmp;
	logic [CMP_W-1:0]  rhs_cmp;
	logic              above;
	logic              below;

	always_comb begin
		if (cfg.window_length == '0) begin
			nw_eff = NW_W'(1);
		end else if (32'(cfg.window_length) > 32'(MAX_WINDOW)) begin
			nw_eff = NW_W'(MAX_WINDOW);
		end else begin
			nw_eff = NW_W'(cfg.window_length);
		end
	end

	assign adv      = !out_vld_q || m_tready;
	assign pop      = adv && !fifo_stat.empty;
	assign last_pos = (pos_q == POS_W'(nw_eff - NW_W'(1)));
	// entry being read is written by the stage ahead at the same edge
	assign fwd_now  = vld_s1 && (pos_s1 == pos_q);

	always_comb begin
		if (!old_ok_s1) begin
			old_flux = '0;
		end else if (fwd_s1) begin
			old_flux = fwd_val_s1;
		end else begin
			old_flux = rd_s1;
		end
		sum_new = sum_q - SUM_W'(old_flux) + SUM_W'(flux_s1);
	end

	assign lhs_cmp = CMP_W'({lhs_s3, {sfod_pkg::GAIN_FRAC{1'b0}}});
	assign rhs_cmp = CMP_W'(rhs_s3);
	assign above   = lhs_cmp > rhs_cmp;
	assign below   = lhs_cmp < rhs_cmp;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			sfod_pkg::ST_NONE: begin
				if (above) state_next = sfod_pkg::ST_BEGIN;
			end
			sfod_pkg::ST_BEGIN: begin
				if (above) state_next = sfod_pkg::ST_DURATION;
				else if (below) state_next = sfod_pkg::ST_ENDED;
			end
			sfod_pkg::ST_DURATION: begin
				if (below) state_next = sfod_pkg::ST_ENDED;
			end
			sfod_pkg::ST_ENDED: begin
				if (above) state_next = sfod_pkg::ST_BEGIN;
				else if (below) state_next = sfod_pkg::ST_NONE;
			end
			default: state_next = sfod_pkg::ST_NONE;
		endcase
	end

	always_comb begin
		res_state = sfod_pkg::STATE_W'(state_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_vld_q <= 1'b0;
			pos_q     <= '0;
			wrapped_q <= 1'b0;
			sum_q     <= '0;
			state_q   <= sfod_pkg::ST_NONE;
		end else if (clear) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_vld_q <= 1'b0;
			pos_q     <= '0;
			wrapped_q <= 1'b0;
			sum_q     <= '0;
			state_q   <= sfod_pkg::ST_NONE;
		end else begin
			if (adv) begin
				vld_s1    <= pop;
				vld_s2    <= vld_s1;
				vld_s3    <= vld_s2;
				out_vld_q <= vld_s3;
				if (vld_s1) begin
					sum_q <= sum_new;
				end
				if (vld_s3) begin
					state_q <= state_next;
				end
			end
			if (pop) begin
				pos_q <= last_pos ? '0 : pos_q + POS_W'(1);
				if (last_pos) begin
					wrapped_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (pop) begin
				flux_s1    <= fifo_data;
				pos_s1     <= pos_q;
				fwd_s1     <= fwd_now;
				old_ok_s1  <= wrapped_q || fwd_now;
				fwd_val_s1 <= flux_s1;
			end
			flux_s2 <= flux_s1;
			sum_s2  <= sum_new;
			lhs_s2  <= LHS_W'(flux_s1) * LHS_W'(nw_eff);
			flux_s3 <= flux_s2;
			lhs_s3  <= lhs_s2;
			rhs_s3  <= RHS_W'(sum_s2) * RHS_W'(cfg.gain);
			if (vld_s3) begin
				out_flux_q <= flux_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			ring_mem[pos_s1] <= flux_s1;
		end
		if (pop) begin
			rd_s1 <= ring_mem[pos_q];
		end
	end

	assign m_tvalid = out_vld_q;
	assign res_flux = out_flux_q;

endmodule

FILE: sv/spectral_flux_onset_detector_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spectral_flux_onset_detector_unit
// Spectral flux onset detector with moving-average adaptive threshold.
// ---------------------------------------------------------------------------
// Input stream s_*: one magnitude bin per request, frame_bins bins per frame,
// in frame order. Output stream m_*: one request per finished frame with the
// onset state after that frame and the frame's flux.
// Config port: cfg_we/cfg_addr/cfg_wdata, index 0 frame_bins, 1 window_length,
// 2 gain (Q4.12). A write to a valid index clears all detector state; index 3
// is ignored.
// Throughput: one bin per cycle while the frame queue has room, frames of any
// length down to one bin. A frame's result shows on m_tvalid after its last
// bin is accepted, passing the bin path stage, the frame queue, the
// three-stage ring sum / multiply / compare path and the result register.
// Reset: registers take 512 bins, window 8, gain 1.0; previous-frame store
// and flux ring read as zero until first written, no clearing pass.
// Receiver stall: the result register and back end hold, the 4-entry frame
// queue fills, and s_tready drops only when the queue has no room.
// ---------------------------------------------------------------------------
`include "spectral_flux_onset_detector_unit_defines.svh"

module spectral_flux_onset_detector_unit #(
	parameter int MAX_BINS   = sfod_pkg::DEF_MAX_BINS,
	parameter int MAX_WINDOW = sfod_pkg::DEF_MAX_WINDOW,
	parameter int MAG_BITS   = sfod_pkg::DEF_MAG_BITS,
	localparam int IN_W      = ((MAG_BITS + 7) / 8) * 8,
	localparam int FLUX_W    = MAG_BITS + $clog2(MAX_BINS),
	localparam int OUT_W     = ((sfod_pkg::STATE_W + FLUX_W + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sfod_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [sfod_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [IN_W-1:0]                 s_tdata,  // magnitude
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [OUT_W-1:0]                m_tdata   // onset_state, flux
);

	sfod_pkg::cfg_regs_t    cfg_q;
	logic                   clear;
	sfod_pkg::fifo_status_t fifo_stat;
	logic                   push;
	logic [FLUX_W-1:0]      push_data;
	logic                   pop;
	logic [FLUX_W-1:0]      pop_data;
	logic [sfod_pkg::STATE_W-1:0] res_state;
	logic [FLUX_W-1:0]      res_flux;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_bins    <= sfod_pkg::RST_FRAME_BINS;
			cfg_q.window_length <= sfod_pkg::RST_WINDOW;
			cfg_q.gain          <= sfod_pkg::RST_GAIN;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				sfod_pkg::CFG_FRAME_BINS:
					cfg_q.frame_bins <= cfg_wdata[sfod_pkg::FRAME_BINS_W-1:0];
				sfod_pkg::CFG_WINDOW_LENGTH:
					cfg_q.window_length <= cfg_wdata[sfod_pkg::WINDOW_W-1:0];
				sfod_pkg::CFG_GAIN:
					cfg_q.gain <= cfg_wdata[sfod_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		clear = 1'b0;
		if (cfg_we) begin
			unique case (cfg_addr) inside
				sfod_pkg::CFG_FRAME_BINS,
				sfod_pkg::CFG_WINDOW_LENGTH,
				sfod_pkg::CFG_GAIN: clear = 1'b1;
				default: clear = 1'b0;
			endcase
		end
	end

	sfod_front #(
		.MAX_BINS (MAX_BINS),
		.MAG_BITS (MAG_BITS),
		.FLUX_W   (FLUX_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (clear),
		.cfg       (cfg_q),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.mag       (s_tdata[MAG_BITS-1:0]),
		.fifo_stat (fifo_stat),
		.push      (push),
		.push_data (push_data)
	);

	sfod_fifo #(
		.WIDTH (FLUX_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (clear),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (fifo_stat)
	);

	sfod_back #(
		.MAX_WINDOW (MAX_WINDOW),
		.FLUX_W     (FLUX_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (clear),
		.cfg       (cfg_q),
		.fifo_stat (fifo_stat),
		.fifo_data (pop_data),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.res_state (res_state),
		.res_flux  (res_flux)
	);

	assign m_tdata = OUT_W'({res_flux, res_state});

	`SFOD_ASSERT_NEVER(a_fifo_bound, 32'(fifo_stat.count) > sfod_pkg::FIFO_DEPTH, "frame queue overfilled")
	`SFOD_ASSERT_IMPL(a_accept_room, s_tvalid && s_tready, 32'(fifo_stat.count) < sfod_pkg::FIFO_DEPTH, "bin accepted with frame queue full")
	`SFOD_ASSERT_NEXT(a_clear_flush, clear, fifo_stat.empty && !m_tvalid, "state not flushed by config write")

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the spectral flux onset detector.
// Magnitude bins stream in under random idling and a long receiver hold-off.
// A local model of the bin store, flux ring and onset machine predicts every
// frame's state and flux, and each result is compared in arrival order. The
// run steps through several register settings, the extremes among them.
// ---------------------------------------------------------------------------
module testbench;

	localparam int BINS_MAX   = sfod_pkg::DEF_MAX_BINS;
	localparam int WINDOW_MAX = sfod_pkg::DEF_MAX_WINDOW;
	localparam int MAG_W      = sfod_pkg::DEF_MAG_BITS;
	localparam int IN_W       = ((MAG_W + 7) / 8) * 8;
	localparam int FLUX_W     = MAG_W + $clog2(BINS_MAX);
	localparam int OUT_W      = ((sfod_pkg::STATE_W + FLUX_W + 7) / 8) * 8;
	localparam int QUIET_LIMIT   = 3000;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASES        = 12;
	localparam logic [sfod_pkg::CFG_ADDR_W-1:0] CFG_NO_REG = 2'd3;

	typedef struct {
		sfod_pkg::onset_t   state;
		logic [FLUX_W-1:0]  flux;
	} frame_result_t;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            cfg_we    = 1'b0;
	logic [sfod_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
	logic [sfod_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	logic [IN_W-1:0]                 s_tdata   = '0;  // magnitude
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	logic [OUT_W-1:0]                m_tdata;         // onset_state, flux

	spectral_flux_onset_detector_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #10 clk = ~clk;

	// detector model state
	logic [sfod_pkg::FRAME_BINS_W-1:0] cfg_frame_bins;
	logic [sfod_pkg::WINDOW_W-1:0]     cfg_window;
	logic [sfod_pkg::GAIN_W-1:0]       cfg_gain;
	logic [MAG_W-1:0]        last_mag [BINS_MAX];
	logic [FLUX_W-1:0]       flux_hist [WINDOW_MAX];
	logic [FLUX_W-1:0]       flux_run;
	logic [30:0]             hist_sum;
	int                      bin_pos;
	int                      hist_pos;
	sfod_pkg::onset_t        onset_now;

	frame_result_t    expected_frames [$];
	logic [MAG_W-1:0] pending_bins [$];
	int  bins_queued   = 0;
	int  bins_accepted = 0;
	int  mismatches    = 0;
	int  quiet_cycles  = 0;
	int  send_idle_pct = 10;
	int  recv_stall_pct = 81;
	int  stall_left    = 0;
	bit  stall_burst_pending = 1'b0;
	bit  bin_taken     = 1'b0;
	bit  frame_taken   = 1'b0;

	function automatic void clear_detector();
		foreach (last_mag[i]) last_mag[i] = '0;
		foreach (flux_hist[i]) flux_hist[i] = '0;
		flux_run  = '0;
		hist_sum  = '0;
		bin_pos   = 0;
		hist_pos  = 0;
		onset_now = sfod_pkg::ST_NONE;
	endfunction

	function automatic void apply_register(logic [sfod_pkg::CFG_ADDR_W-1:0] idx,
			logic [sfod_pkg::CFG_DATA_W-1:0] val);
		case (idx)
			sfod_pkg::CFG_FRAME_BINS: begin
				cfg_frame_bins = val[sfod_pkg::FRAME_BINS_W-1:0];
			end
			sfod_pkg::CFG_WINDOW_LENGTH: begin
				cfg_window = val[sfod_pkg::WINDOW_W-1:0];
			end
			sfod_pkg::CFG_GAIN: begin
				cfg_gain = val[sfod_pkg::GAIN_W-1:0];
			end
			default: begin
				return;
			end
		endcase
		clear_detector();
	endfunction

	function automatic int eff_frame_len(logic [sfod_pkg::FRAME_BINS_W-1:0] fb);
		if (fb == 0) return 1;
		if (fb > BINS_MAX) return BINS_MAX;
		return int'(fb);
	endfunction

	// one bin into the flux accumulator; a finished frame yields a result
	function automatic void absorb_bin(logic [MAG_W-1:0] mag);
		int                unsigned nw;
		logic [MAG_W-1:0]  old;
		logic [FLUX_W-1:0] flux;
		longint unsigned   lhs;
		longint unsigned   rhs;
		bit                above;
		bit                below;
		nw = (cfg_window == 0) ? 1 : ((cfg_window > WINDOW_MAX) ? WINDOW_MAX : cfg_window);
		old = last_mag[bin_pos];
		flux_run += (mag >= old) ? (mag - old) : (old - mag);
		last_mag[bin_pos] = mag;
		bin_pos++;
		if (bin_pos < eff_frame_len(cfg_frame_bins)) return;
		flux     = flux_run;
		flux_run = '0;
		bin_pos  = 0;
		if (hist_pos >= nw) hist_pos = 0;
		hist_sum = hist_sum - flux_hist[hist_pos] + flux;
		flux_hist[hist_pos] = flux;
		hist_pos++;
		if (hist_pos >= nw) hist_pos = 0;
		lhs   = 64'(flux) * 64'(nw) * 64'd4096;
		rhs   = 64'(hist_sum) * 64'(cfg_gain);
		above = lhs > rhs;
		below = lhs < rhs;
		case (onset_now)
			sfod_pkg::ST_NONE: begin
				if (above) onset_now = sfod_pkg::ST_BEGIN;
			end
			sfod_pkg::ST_BEGIN: begin
				if (above) onset_now = sfod_pkg::ST_DURATION;
				else if (below) onset_now = sfod_pkg::ST_ENDED;
			end
			sfod_pkg::ST_DURATION: begin
				if (below) onset_now = sfod_pkg::ST_ENDED;
			end
			default: begin
				if (above) onset_now = sfod_pkg::ST_BEGIN;
				else if (below) onset_now = sfod_pkg::ST_NONE;
			end
		endcase
		expected_frames.push_back('{onset_now, flux});
	endfunction

	task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
		mismatches++;
		$display("mismatch: %s got %0d want %0d at %0t", what, got, want, $realtime);
	endtask

	// request source
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && !bin_taken) begin
				// hold the offered bin
			end else if (pending_bins.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata  <= IN_W'(pending_bins.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result sink
	always @(negedge clk) begin
		if (stall_burst_pending) begin
			stall_left = HOLD_CYCLES;
			stall_burst_pending = 1'b0;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor, checker, watchdog
	always @(posedge clk) begin
		frame_result_t want;
		bin_taken   = arst_n && s_tvalid && s_tready;
		frame_taken = arst_n && m_tvalid && m_tready;
		if (frame_taken) begin
			if (expected_frames.size() == 0) begin
				flag_mismatch("result with no frame pending", m_tdata, 0);
			end else begin
				want = expected_frames.pop_front();
				if (m_tdata[sfod_pkg::STATE_W-1:0] !== want.state)
					flag_mismatch("onset_state", m_tdata[sfod_pkg::STATE_W-1:0], want.state);
				if (m_tdata[sfod_pkg::STATE_W +: FLUX_W] !== want.flux)
					flag_mismatch("flux", m_tdata[sfod_pkg::STATE_W +: FLUX_W], want.flux);
			end
		end
		if (bin_taken) begin
			bins_accepted++;
			absorb_bin(s_tdata[MAG_W-1:0]);
		end
		if (bin_taken || frame_taken) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic wait_drained();
		while (bins_accepted != bins_queued || expected_frames.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [sfod_pkg::CFG_ADDR_W-1:0] idx,
			logic [sfod_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		apply_register(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_bin(logic [MAG_W-1:0] mag);
		pending_bins.push_back(mag);
		bins_queued++;
	endtask

	// quiet frames with occasional loud ones, plus some full-range noise
	task automatic queue_spectra(int n, int frame_len);
		bit loud;
		loud = 1'b0;
		for (int i = 0; i < n; i++) begin
			if (i % frame_len == 0) loud = ($urandom_range(3) == 0);
			if (loud || $urandom_range(9) == 0) queue_bin(MAG_W'($urandom()));
			else queue_bin(MAG_W'($urandom_range(64)));
		end
	endtask

	initial begin
		logic [sfod_pkg::CFG_DATA_W-1:0] ph_frame [PHASES];
		logic [sfod_pkg::CFG_DATA_W-1:0] ph_window [PHASES];
		logic [sfod_pkg::CFG_DATA_W-1:0] ph_gain [PHASES];
		logic [MAG_W-1:0]                onset_seq [10];
		int                              n_bins;
		int                              frame_len;
		ph_frame  = '{16'd1023, 16'd3, 16'd2, 16'd7, 16'd1, 16'hFC05,
			16'd8, 16'd4, 16'd1, 16'd6, 16'd2, 16'd0};
		ph_window = '{16'd127, 16'd1, 16'd64, 16'd5, 16'd8, 16'hFF83,
			16'd0, 16'd16, 16'd2, 16'd32, 16'd3, 16'd0};
		ph_gain   = '{16'd65535, 16'd4096, 16'd5000, 16'd0, 16'd4096, 16'd2048,
			16'd6000, 16'd3000, 16'd4096, 16'd8192, 16'd65535, 16'd0};
		onset_seq = '{16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'h5555, 16'hAAAA, 16'h0000};
		ph_frame[PHASES-1]  = sfod_pkg::CFG_DATA_W'($urandom_range(8, 1));
		ph_window[PHASES-1] = sfod_pkg::CFG_DATA_W'($urandom_range(127));
		ph_gain[PHASES-1]   = sfod_pkg::CFG_DATA_W'($urandom());

		cfg_frame_bins = sfod_pkg::RST_FRAME_BINS;
		cfg_window     = sfod_pkg::RST_WINDOW;
		cfg_gain       = sfod_pkg::RST_GAIN;
		clear_detector();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// directed: one-bin frames through every onset transition
		write_reg(sfod_pkg::CFG_FRAME_BINS, 16'd0);
		write_reg(sfod_pkg::CFG_WINDOW_LENGTH, 16'd4);
		write_reg(sfod_pkg::CFG_GAIN, 16'd4096);
		foreach (onset_seq[i])
			queue_bin(onset_seq[i]);
		wait_drained();
		// window of one with unit gain: every frame ties
		write_reg(sfod_pkg::CFG_WINDOW_LENGTH, 16'd0);
		queue_bin(16'd1234);
		queue_bin(16'd0);
		queue_bin(16'hFFFF);
		wait_drained();
		// zero gain: any nonzero flux is above
		write_reg(sfod_pkg::CFG_GAIN, 16'd0);
		queue_bin(16'd0);
		queue_bin(16'd7);
		queue_bin(16'd7);
		queue_bin(16'd0);
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			if (p == 4) begin
				send_idle_pct  = 81;
				recv_stall_pct = 10;
			end else if (p == 8) begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			write_reg(sfod_pkg::CFG_FRAME_BINS, ph_frame[p]);
			write_reg(sfod_pkg::CFG_WINDOW_LENGTH, ph_window[p]);
			write_reg(sfod_pkg::CFG_GAIN, ph_gain[p]);
			frame_len = eff_frame_len(ph_frame[p][sfod_pkg::FRAME_BINS_W-1:0]);
			n_bins = (frame_len > 64) ? 2 * frame_len + 30 : $urandom_range(72, 52);
			if (p == 8) stall_burst_pending = 1'b1;
			queue_spectra(n_bins / 2, frame_len);
			wait_drained();
			// unused index: ignored, partial frame must survive
			write_reg(CFG_NO_REG, sfod_pkg::CFG_DATA_W'($urandom()));
			queue_spectra(n_bins - n_bins / 2, frame_len);
			wait_drained();
		end

		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/sfod_pkg.sv
sv/sfod_front.sv
sv/sfod_fifo.sv
sv/sfod_back.sv
sv/spectral_flux_onset_detector_unit.sv
test/testbench.sv
